### rtl/ltdd_pkg.sv
`default_nettype none
package ltdd_pkg;
  localparam int NumIds = 16;
  localparam int IdW = 4;

  localparam logic [2:0] ST_GRANTED = 3'd0;
  localparam logic [2:0] ST_WAITING = 3'd1;
  localparam logic [2:0] ST_FREED   = 3'd2;
  localparam logic [2:0] ST_HANDED  = 3'd3;
  localparam logic [2:0] ST_IGNORED = 3'd4;
  localparam logic [2:0] ST_HOP     = 3'd5;
  localparam logic [2:0] ST_HALTED  = 3'd6;

  localparam logic OP_ACQUIRE = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  typedef struct packed {
    logic [2:0]     status;
    logic [IdW-1:0] hop_process;
    logic [IdW-1:0] hop_resource;
    logic [IdW-1:0] hop_holder;
    logic [IdW-1:0] new_owner;
    logic           last;
  } result_t;
endpackage
`default_nettype wire

### rtl/lock_table_deadlock_detector_unit.sv
// Lock table with wait-for deadlock search. One request at a time. Grant, ignore
// and halted answers are settled in the decode state and go straight to output. A
// release by the owner first scans the waiters one process per cycle, lowest
// first, and answers freed if none waits. An acquire of a held resource, or a release
// that finds a waiter, runs a depth-first search that examines one
// (process, resource) pair per cycle and backtracks when a process is exhausted.
// Without a deadlock it answers waiting or handed; a deadlock is emitted one hop per result.
// in_ready is low from acceptance until the last result is taken. After a
// deadlock the block halts and answers every request with status halted.
`default_nettype none
module lock_table_deadlock_detector_unit
  import ltdd_pkg::*;
(
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic           opcode,
  input  wire logic [IdW-1:0] process_id,
  input  wire logic [IdW-1:0] resource_id,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [2:0]          status,
  output logic [IdW-1:0]      hop_process,
  output logic [IdW-1:0]      hop_resource,
  output logic [IdW-1:0]      hop_holder,
  output logic [IdW-1:0]      new_owner,
  output logic                last
);
  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_SCAN, S_SEARCH, S_EMIT, S_OUT
  } state_t;

  state_t state;
  logic [NumIds-1:0]   owner_valid;
  logic [IdW-1:0]      owner_process [NumIds];
  logic [NumIds-1:0]   wait_bits [NumIds];
  logic                halted;
  logic [NumIds-1:0]   visited_set;
  logic [IdW-1:0]      stack_process [NumIds];
  logic [IdW:0]        stack_cursor [NumIds];
  logic [IdW:0]        stack_depth;
  logic                req_op;
  logic [IdW-1:0]      req_p, req_r, start, emit_owner, scan_i;
  logic [IdW-1:0]      emit_k;
  result_t             res;

  // current top of stack
  logic [IdW-1:0] top_d, top_p, top_r, hold;
  logic [IdW:0]   top_c;
  assign top_d = IdW'(stack_depth - 1'b1);
  assign top_p = stack_process[top_d];
  assign top_c = stack_cursor[top_d];
  assign top_r = top_c[IdW-1:0];
  assign hold  = owner_process[top_r];

  logic [IdW-1:0] ek_r;
  assign ek_r = stack_cursor[emit_k][IdW-1:0];

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign status       = res.status;
  assign hop_process  = res.hop_process;
  assign hop_resource = res.hop_resource;
  assign hop_holder   = res.hop_holder;
  assign new_owner    = res.new_owner;
  assign last         = res.last;

  function automatic result_t one(input logic [2:0] st, input logic [IdW-1:0] no);
    result_t t;
    t = '0;
    t.status = st;
    t.new_owner = no;
    t.last = 1'b1;
    return t;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      owner_valid <= '0;
      halted <= 1'b0;
      stack_depth <= '0;
      for (int i = 0; i < NumIds; i++) wait_bits[i] <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) begin
          req_op <= opcode;
          req_p <= process_id;
          req_r <= resource_id;
          state <= S_DECODE;
        end
        S_DECODE: begin
          if (halted) begin
            res <= one(ST_HALTED, '0);
            state <= S_OUT;
          end else if (req_op == OP_ACQUIRE) begin
            if (!owner_valid[req_r]) begin
              owner_valid[req_r] <= 1'b1;
              owner_process[req_r] <= req_p;
              res <= one(ST_GRANTED, req_p);
              state <= S_OUT;
            end else begin
              wait_bits[req_p][req_r] <= 1'b1;
              start <= req_p;
              emit_owner <= '0;
              state <= S_SEARCH;
              visited_set <= NumIds'(1) << req_p;
              stack_process[0] <= req_p;
              stack_cursor[0] <= '0;
              stack_depth <= (IdW+1)'(1);
            end
          end else if (!owner_valid[req_r] || owner_process[req_r] != req_p) begin
            res <= one(ST_IGNORED, '0);
            state <= S_OUT;
          end else begin
            scan_i <= '0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          // find lowest waiter, one process per cycle
          if (wait_bits[scan_i][req_r]) begin
            wait_bits[scan_i][req_r] <= 1'b0;
            owner_process[req_r] <= scan_i;
            start <= scan_i;
            emit_owner <= scan_i;
            visited_set <= NumIds'(1) << scan_i;
            stack_process[0] <= scan_i;
            stack_cursor[0] <= '0;
            stack_depth <= (IdW+1)'(1);
            state <= S_SEARCH;
          end else if (scan_i == IdW'(NumIds - 1)) begin
            owner_valid[req_r] <= 1'b0;
            res <= one(ST_FREED, '0);
            state <= S_OUT;
          end else scan_i <= scan_i + 1'b1;
        end
        S_SEARCH: begin
          if (stack_depth == '0) begin
            res <= one(emit_owner == '0 && req_op == OP_ACQUIRE ? ST_WAITING : ST_HANDED,
                       req_op == OP_ACQUIRE ? '0 : emit_owner);
            state <= S_OUT;
          end else if (top_c[IdW]) begin
            stack_depth <= stack_depth - 1'b1;
            if (stack_depth > (IdW+1)'(1))
              stack_cursor[top_d - 1'b1] <= stack_cursor[top_d - 1'b1] + 1'b1;
          end else if (!wait_bits[top_p][top_r] || !owner_valid[top_r]) begin
            stack_cursor[top_d] <= top_c + 1'b1;
          end else if (hold == start) begin
            emit_k <= '0;
            state <= S_EMIT;
          end else if (visited_set[hold] || stack_depth[IdW]) begin
            stack_cursor[top_d] <= top_c + 1'b1;
          end else begin
            visited_set[hold] <= 1'b1;
            stack_process[IdW'(stack_depth)] <= hold;
            stack_cursor[IdW'(stack_depth)] <= '0;
            stack_depth <= stack_depth + 1'b1;
          end
        end
        S_EMIT: begin
          res.status <= ST_HOP;
          res.hop_process <= stack_process[emit_k];
          res.hop_resource <= ek_r;
          res.hop_holder <= owner_process[ek_r];
          res.new_owner <= emit_owner;
          res.last <= ((IdW+1)'(emit_k) + 1'b1) == stack_depth;
          halted <= 1'b1;
          state <= S_OUT;
        end
        S_OUT: if (out_ready) begin
          if (res.last) state <= S_IDLE;
          else begin
            emit_k <= emit_k + 1'b1;
            state <= S_EMIT;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_one_side: assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("input and output sides both open");
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst) $past(halted) |-> halted)
    else $error("halt cleared");
  a_hop_halts: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_HOP) |-> halted)
    else $error("hop without halt");
endmodule
`default_nettype wire

### verif/tb.sv
`default_nettype none
module tb;
  import ltdd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int StallLimit = 6000;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           in_valid = 1'b0;
  logic           in_ready;
  logic           opcode = OP_ACQUIRE;
  logic [IdW-1:0] process_id = '0;
  logic [IdW-1:0] resource_id = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  logic [2:0]     status;
  logic [IdW-1:0] hop_process;
  logic [IdW-1:0] hop_resource;
  logic [IdW-1:0] hop_holder;
  logic [IdW-1:0] new_owner;
  logic           last;

  lock_table_deadlock_detector_unit dut (
    .clk, .rst, .in_valid, .in_ready, .opcode, .process_id, .resource_id,
    .out_valid, .out_ready, .status, .hop_process, .hop_resource, .hop_holder,
    .new_owner, .last
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Lock table mirror
  bit       held[NumIds];
  int       holder_of[NumIds];
  bit [NumIds-1:0] wait_map[NumIds];
  bit       is_halted;
  bit [NumIds-1:0] seen;
  int       path_proc[NumIds];
  int       path_res[NumIds];
  int       path_len;

  result_t  lock_answers[$];
  int       errors;
  int       requests_sent;
  int       hops_seen;
  int       idle_cycles;
  bit       long_hold_req;

  function automatic result_t make_answer(logic [2:0] st, int hp, int hr, int hh,
                                          int no, bit fin);
    result_t a;
    a.status = st;
    a.hop_process = IdW'(hp);
    a.hop_resource = IdW'(hr);
    a.hop_holder = IdW'(hh);
    a.new_owner = IdW'(no);
    a.last = fin;
    return a;
  endfunction

  function automatic bit find_cycle(input int start);
    int d, p, r, h;
    seen = '0;
    seen[start] = 1'b1;
    path_proc[0] = start;
    path_res[0] = 0;
    path_len = 1;
    while (path_len > 0) begin
      d = path_len - 1;
      p = path_proc[d];
      r = path_res[d];
      if (r >= NumIds) begin
        path_len--;
        if (path_len > 0) path_res[path_len-1]++;
        continue;
      end
      if (!wait_map[p][r] || !held[r]) begin
        path_res[d]++;
        continue;
      end
      h = holder_of[r];
      if (h == start) return 1'b1;
      if (seen[h] || path_len >= NumIds) begin
        path_res[d]++;
        continue;
      end
      seen[h] = 1'b1;
      path_proc[path_len] = h;
      path_res[path_len] = 0;
      path_len++;
    end
    return 1'b0;
  endfunction

  function automatic void push_cycle(int owner, ref result_t q[$]);
    for (int k = 0; k < path_len; k++)
      q.push_back(make_answer(ST_HOP, path_proc[k], path_res[k],
                              holder_of[path_res[k]], owner, k + 1 == path_len));
    is_halted = 1'b1;
  endfunction

  function automatic void predict_lock(logic op, int p, int r, ref result_t q[$]);
    if (is_halted) begin
      q.push_back(make_answer(ST_HALTED, 0, 0, 0, 0, 1'b1));
      return;
    end
    if (op == OP_ACQUIRE) begin
      if (!held[r]) begin
        held[r] = 1'b1;
        holder_of[r] = p;
        q.push_back(make_answer(ST_GRANTED, 0, 0, 0, p, 1'b1));
        return;
      end
      wait_map[p][r] = 1'b1;
      if (find_cycle(p)) push_cycle(0, q);
      else q.push_back(make_answer(ST_WAITING, 0, 0, 0, 0, 1'b1));
      return;
    end
    if (!held[r] || holder_of[r] != p) begin
      q.push_back(make_answer(ST_IGNORED, 0, 0, 0, 0, 1'b1));
      return;
    end
    held[r] = 1'b0;
    for (int i = 0; i < NumIds; i++) begin
      if (wait_map[i][r]) begin
        wait_map[i][r] = 1'b0;
        held[r] = 1'b1;
        holder_of[r] = i;
        if (find_cycle(i)) push_cycle(i, q);
        else q.push_back(make_answer(ST_HANDED, 0, 0, 0, i, 1'b1));
        return;
      end
    end
    q.push_back(make_answer(ST_FREED, 0, 0, 0, 0, 1'b1));
  endfunction

  // Dry run on the live table, restored from a saved copy; true if the request would end in deadlock.
  function automatic bit would_deadlock(logic op, int p, int r);
    bit              held_s[NumIds];
    int              holder_s[NumIds];
    bit [NumIds-1:0] wait_s[NumIds];
    result_t         scratch[$];
    bit              found;
    held_s = held;
    holder_s = holder_of;
    wait_s = wait_map;
    predict_lock(op, p, r, scratch);
    found = is_halted;
    held = held_s;
    holder_of = holder_s;
    wait_map = wait_s;
    is_halted = 1'b0;
    return found;
  endfunction

  task automatic report(string what);
    errors++;
    $display("MISMATCH @%0t: %s", $realtime, what);
  endtask

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return 0;
    if (roll < 93) return $urandom_range(1, 4);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_request(logic op, int p, int r);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    opcode <= op;
    process_id <= IdW'(p);
    resource_id <= IdW'(r);
    do @(posedge clk); while (!in_ready);
    predict_lock(op, p, r, lock_answers);
    requests_sent++;
  endtask

  // Receiver: mostly ready, short stalls, the odd long one.
  initial begin
    int n;
    int roll;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (250) @(negedge clk);
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 65) begin
          out_ready <= 1'b1;
          n = $urandom_range(1, 25);
        end else begin
          out_ready <= 1'b0;
          n = (roll < 96) ? $urandom_range(1, 3) : $urandom_range(20, 60);
        end
        repeat (n - 1) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (lock_answers.size() == 0) begin
        report($sformatf("unexpected result status %0d", status));
      end else begin
        want = lock_answers.pop_front();
        if (status == ST_HOP) hops_seen++;
        if (status !== want.status)
          report($sformatf("status %0d, want %0d", status, want.status));
        if (hop_process !== want.hop_process)
          report($sformatf("hop_process %0d, want %0d", hop_process, want.hop_process));
        if (hop_resource !== want.hop_resource)
          report($sformatf("hop_resource %0d, want %0d", hop_resource, want.hop_resource));
        if (hop_holder !== want.hop_holder)
          report($sformatf("hop_holder %0d, want %0d", hop_holder, want.hop_holder));
        if (new_owner !== want.new_owner)
          report($sformatf("new_owner %0d, want %0d", new_owner, want.new_owner));
        if (last !== want.last)
          report($sformatf("last %0d, want %0d", last, want.last));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("watchdog: no handshake for %0d cycles", StallLimit);
        $display("lock_table_deadlock_detector_unit verification failed");
        $finish;
      end
    end
  end

  task automatic test_directed();
    send_request(OP_ACQUIRE, 0, 0);
    send_request(OP_ACQUIRE, 15, 15);
    send_request(OP_ACQUIRE, 15, 0);
    send_request(OP_RELEASE, 3, 0);
    send_request(OP_RELEASE, 5, 5);
    send_request(OP_RELEASE, 0, 0);
    send_request(OP_RELEASE, 15, 0);
    send_request(OP_RELEASE, 15, 15);
    send_request(OP_ACQUIRE, 9, 7);
    send_request(OP_ACQUIRE, 4, 7);
    send_request(OP_ACQUIRE, 2, 7);
    send_request(OP_RELEASE, 9, 7);
    send_request(OP_RELEASE, 2, 7);
    send_request(OP_RELEASE, 4, 7);
    send_request(OP_ACQUIRE, 10, 5);
    send_request(OP_ACQUIRE, 5, 10);
    send_request(OP_RELEASE, 5, 5);
  endtask

  // Random request; safe ones steer clear of any wait-for cycle.
  task automatic random_request(bit safe);
    logic op;
    int   p;
    int   r;
    int   tries;
    tries = 0;
    do begin
      r = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 5);
      p = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 5);
      op = ($urandom_range(0, 99) < 55) ? OP_ACQUIRE : OP_RELEASE;
      // mostly release by the owner
      if (op == OP_RELEASE && held[r] && $urandom_range(0, 9) < 8) p = holder_of[r];
      tries++;
    end while (safe && tries < 50 && would_deadlock(op, p, r));
    if (safe && would_deadlock(op, p, r)) op = OP_RELEASE;
    if (safe && would_deadlock(op, p, r)) p = (holder_of[r] + 1) % NumIds;
    send_request(op, p, r);
  endtask

  task automatic test_random_traffic();
    repeat (280) random_request(1'b1);
  endtask

  task automatic test_input_backpressure();
    long_hold_req = 1'b1;
    repeat (12) random_request(1'b1);
  endtask

  task automatic test_deadlock_and_halt();
    int mode;
    int p;
    int r;
    mode = $urandom_range(0, 1);
    if (mode == 0) begin
      // self-wait on a held resource
      r = $urandom_range(0, 15);
      p = held[r] ? holder_of[r] : $urandom_range(0, 15);
      if (!held[r]) send_request(OP_ACQUIRE, p, r);
      send_request(OP_ACQUIRE, p, r);
    end else begin
      for (int i = 0; i < 20 && !is_halted; i++) random_request(1'b0);
      if (!is_halted) begin
        r = $urandom_range(0, 15);
        p = held[r] ? holder_of[r] : 0;
        if (!held[r]) send_request(OP_ACQUIRE, p, r);
        send_request(OP_ACQUIRE, p, r);
      end
    end
    repeat (6) random_request(1'b0);
  endtask

  initial begin
    for (int i = 0; i < NumIds; i++) begin
      held[i] = 1'b0;
      holder_of[i] = 0;
      wait_map[i] = '0;
    end
    is_halted = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_traffic();
    test_input_backpressure();
    test_deadlock_and_halt();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (lock_answers.size() == 0);
    repeat (30) @(posedge clk);
    $display("covered %0d requests: grants, waits, handovers, frees, ignored releases,",
             requests_sent);
    $display("a %0d-hop deadlock report and halted answers afterwards", hops_seen);
    if (errors == 0 && lock_answers.size() == 0) begin
      $display("lock_table_deadlock_detector_unit verification clean");
    end else begin
      $display("lock_table_deadlock_detector_unit verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

### filelist.f
rtl/ltdd_pkg.sv
rtl/lock_table_deadlock_detector_unit.sv
verif/tb.sv
